[design/masked_crosstalk_fir_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for masked_crosstalk_fir
// Clocked assertion wrappers; the checker takes them by include.
// ----------------------------------------------------------------------------
`ifndef MASKED_CROSSTALK_FIR_ASSERT_SVH
`define MASKED_CROSSTALK_FIR_ASSERT_SVH

// checked only outside reset
`define MCF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in %m");

// checked during reset as well
`define MCF_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed in %m");

`endif

[design/mcf_pkg.sv]
// ----------------------------------------------------------------------------
// mcf_pkg
// Types and constants shared by the crosstalk correction filter.
// ----------------------------------------------------------------------------
package mcf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int TAP_CNT_W    = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_COEFS    = 4;    // coefficient registers that exist
  localparam int MAX_TAPS_DEF = 4;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS    = 15;   // Q1.15 coefficients
  localparam int ACC_W        = PROD_W + 3;
  localparam int Q_W          = ACC_W - FRAC_BITS;
  localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  localparam sample_t SAT_HI = 16'sh7FFF;
  localparam sample_t SAT_LO = 16'sh8000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR  = 3'd4;

  // reset values
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 3'd1;
  localparam coef_t COEF_ONE_RST = 16'sd197;   // 0.006 in Q1.15
  localparam coef_t COEF_ZERO    = '0;

  // current sample plus gated neighbor operands (zero where a tap is skipped)
  typedef struct packed {
    sample_t                    x;
    sample_t [NUM_COEFS-1:0]    opnd;
  } front_t;

  typedef struct packed {
    sample_t                    x;
    prod_t   [NUM_COEFS-1:0]    prod;
  } mult_t;

endpackage

[design/mcf_front.sv]
// ----------------------------------------------------------------------------
// mcf_front
// Input register stage: keeps the channel history and gates neighbor samples
// by frame start, tap count, fill level and mask.
// ----------------------------------------------------------------------------
module mcf_front #(
  parameter int MAX_TAPS = mcf_pkg::MAX_TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  mcf_pkg::sample_t                 sample_in,
  input  logic                             channel_masked,
  input  logic                             frame_start,
  input  logic [mcf_pkg::TAP_CNT_W-1:0]    tap_count,
  output logic                             valid,
  output mcf_pkg::front_t                  stage
);

  // taps past the last coefficient register weigh zero, so no history for them
  localparam int LANES  = (MAX_TAPS < mcf_pkg::NUM_COEFS) ? MAX_TAPS : mcf_pkg::NUM_COEFS;
  localparam int FILL_W = $clog2(LANES + 1);

  mcf_pkg::sample_t          hist_x [LANES];
  logic [LANES-1:0]          hist_m;
  logic [FILL_W-1:0]         fill;
  logic                      accept;
  mcf_pkg::front_t           stage_next;

  assign accept = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      hist_m <= '0;
    end else if (accept) begin
      if (frame_start) begin
        fill   <= FILL_W'(1);
        hist_m <= LANES'(channel_masked);
      end else begin
        fill   <= (fill == FILL_W'(LANES)) ? fill : fill + FILL_W'(1);
        hist_m <= LANES'({hist_m, channel_masked});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_x[0] <= sample_in;
    end
  end

  for (genvar k = 1; k < LANES; k++) begin : g_shift
    always_ff @(posedge clk) begin
      if (accept) begin
        hist_x[k] <= hist_x[k-1];
      end
    end
  end

  assign stage_next.x = sample_in;

  for (genvar j = 0; j < mcf_pkg::NUM_COEFS; j++) begin : g_opnd
    if (j < LANES) begin : g_live
      logic use_tap;
      assign use_tap = !frame_start
                    && (mcf_pkg::TAP_CNT_W'(j) < tap_count)
                    && (FILL_W'(j) < fill)
                    && !hist_m[j];
      assign stage_next.opnd[j] = use_tap ? hist_x[j] : '0;
    end else begin : g_dead
      assign stage_next.opnd[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

[design/mcf_mult.sv]
// ----------------------------------------------------------------------------
// mcf_mult
// Product stage: one signed 16x16 multiplier per tap, registered.
// ----------------------------------------------------------------------------
module mcf_mult (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     valid_in,
  input  mcf_pkg::front_t                          stage_in,
  input  mcf_pkg::coef_t [mcf_pkg::NUM_COEFS-1:0]  coefs,
  output logic                                     valid,
  output mcf_pkg::mult_t                           stage
);

  mcf_pkg::mult_t stage_next;

  assign stage_next.x = stage_in.x;

  for (genvar j = 0; j < mcf_pkg::NUM_COEFS; j++) begin : g_mul
    assign stage_next.prod[j] = $signed(stage_in.opnd[j]) * $signed(coefs[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_in) begin
      stage <= stage_next;
    end
  end

endmodule

[design/mcf_out.sv]
// ----------------------------------------------------------------------------
// mcf_out
// Result stage: sums the products, rounds half up to Q16.0 and saturates.
// ----------------------------------------------------------------------------
module mcf_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  mcf_pkg::mult_t    stage_in,
  output logic              valid,
  output mcf_pkg::sample_t  sample_out,
  output logic              saturated
);

  localparam int ACC_W = mcf_pkg::ACC_W;
  localparam int Q_W   = mcf_pkg::Q_W;
  localparam int TOP   = mcf_pkg::SAMPLE_W - 1;

  logic signed [ACC_W-1:0] acc;
  logic        [Q_W-1:0]   q;
  logic                    over_hi;
  logic                    over_lo;
  mcf_pkg::sample_t        sample_next;

  always_comb begin
    acc = ACC_W'(stage_in.x) <<< mcf_pkg::FRAC_BITS;
    for (int j = 0; j < mcf_pkg::NUM_COEFS; j++) begin
      acc = acc - ACC_W'($signed(stage_in.prod[j]));
    end
    acc = acc + ACC_W'(mcf_pkg::ROUND_HALF);
  end

  // dropping the fraction bits is a floor in two's complement
  assign q       = acc[ACC_W-1:mcf_pkg::FRAC_BITS];
  assign over_hi = !q[Q_W-1] &&  (|q[Q_W-2:TOP]);
  assign over_lo =  q[Q_W-1] && !(&q[Q_W-2:TOP]);

  always_comb begin
    priority if (over_hi) begin
      sample_next = mcf_pkg::SAT_HI;
    end else if (over_lo) begin
      sample_next = mcf_pkg::SAT_LO;
    end else begin
      sample_next = q[mcf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_in) begin
      sample_out <= sample_next;
      saturated  <= over_hi || over_lo;
    end
  end

endmodule

[design/masked_crosstalk_fir.sv]
// Pipeline: an accepted item moves through the front, product and result registers, in that order.
// Throughput: one item per cycle while out_stall is low; the per-tap multipliers and the adder tree
//   each take one pipeline stage, and an item can enter every cycle.
// A stalled output holds the full stages in place; empty stages still fill, and in_stall rises only when all are full.
// Reset (rst, synchronous): empties the pipeline and history, tap_count = 1,
//   coef_one = 197, other coefficients 0.
// ----------------------------------------------------------------------------
// masked_crosstalk_fir
// Strip-channel crosstalk correction FIR with masked neighbors and frame reset.
// ----------------------------------------------------------------------------
module masked_crosstalk_fir #(
  parameter int MAX_TAPS = mcf_pkg::MAX_TAPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mcf_pkg::sample_t                   sample_in,
  input  logic                               channel_masked,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mcf_pkg::sample_t                   sample_out,
  output logic                               saturated
);

  logic [mcf_pkg::TAP_CNT_W-1:0]           tap_count;
  mcf_pkg::coef_t [mcf_pkg::NUM_COEFS-1:0] coefs;

  logic            en_front, en_mult, en_out;
  logic            front_valid, mult_valid;
  mcf_pkg::front_t front_stage;
  mcf_pkg::mult_t  mult_stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= mcf_pkg::TAP_COUNT_RST;
      coefs[0]  <= mcf_pkg::COEF_ONE_RST;
      coefs[1]  <= mcf_pkg::COEF_ZERO;
      coefs[2]  <= mcf_pkg::COEF_ZERO;
      coefs[3]  <= mcf_pkg::COEF_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcf_pkg::REG_TAP_COUNT:  tap_count <= cfg_data[mcf_pkg::TAP_CNT_W-1:0];
        mcf_pkg::REG_COEF_ONE:   coefs[0]  <= cfg_data;
        mcf_pkg::REG_COEF_TWO:   coefs[1]  <= cfg_data;
        mcf_pkg::REG_COEF_THREE: coefs[2]  <= cfg_data;
        mcf_pkg::REG_COEF_FOUR:  coefs[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a stage loads when it is empty or the stage after it moves
  assign en_out   = !out_valid || !out_stall;
  assign en_mult  = !mult_valid || en_out;
  assign en_front = !front_valid || en_mult;
  assign in_stall = !en_front;

  mcf_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en_front),
    .in_valid       (in_valid),
    .sample_in      (sample_in),
    .channel_masked (channel_masked),
    .frame_start    (frame_start),
    .tap_count      (tap_count),
    .valid          (front_valid),
    .stage          (front_stage)
  );

  mcf_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .en       (en_mult),
    .valid_in (front_valid),
    .stage_in (front_stage),
    .coefs    (coefs),
    .valid    (mult_valid),
    .stage    (mult_stage)
  );

  mcf_out u_out (
    .clk        (clk),
    .rst        (rst),
    .en         (en_out),
    .valid_in   (mult_valid),
    .stage_in   (mult_stage),
    .valid      (out_valid),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

endmodule

[design/mcf_checker.sv]
// ----------------------------------------------------------------------------
// mcf_checker
// Port-level checks for masked_crosstalk_fir, attached by bind.
// ----------------------------------------------------------------------------
`include "masked_crosstalk_fir_assert.svh"

module mcf_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input mcf_pkg::sample_t sample_out,
  input logic             saturated
);

  logic [mcf_pkg::SAMPLE_W:0] out_word;
  logic                       at_rail;

  assign out_word = {sample_out, saturated};
  assign at_rail  = (sample_out == mcf_pkg::SAT_HI) || (sample_out == mcf_pkg::SAT_LO);

  `MCF_ASSERT(a_out_valid_holds, out_valid && out_stall |=> out_valid)
  `MCF_ASSERT(a_out_payload_holds, out_valid && out_stall |=> $stable(out_word))
  `MCF_ASSERT(a_sat_at_rail, out_valid && saturated |-> at_rail)
  `MCF_ASSERT(a_empty_out_no_stall, !out_valid |-> !in_stall)
  `MCF_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid && !in_stall)

endmodule

bind masked_crosstalk_fir mcf_checker u_mcf_checker (.*);
